[src/sbs_pkg.sv]
// Shared types and codes for the sentence boundary scanner.
// No dependencies; imported by sbs_step and sentence_boundary_scanner.
package sbs_pkg;

    // Sentence-break class of one code point
    typedef enum logic [3:0] {
        CL_OTHER    = 4'd0,
        CL_CR       = 4'd1,
        CL_LF       = 4'd2,
        CL_SEP      = 4'd3,
        CL_SP       = 4'd4,
        CL_LOWER    = 4'd5,
        CL_UPPER    = 4'd6,
        CL_OLETTER  = 4'd7,
        CL_NUMERIC  = 4'd8,
        CL_ATERM    = 4'd9,
        CL_STERM    = 4'd10,
        CL_CLOSE    = 4'd11,
        CL_SCONT    = 4'd12,
        CL_EXTEND   = 4'd13,
        CL_FORMAT   = 4'd14
    } t_char_class;

    // Scan phase within the current sentence
    typedef enum logic [3:0] {
        PH_START     = 4'd0,
        PH_BODY      = 4'd1,
        PH_UPLOW     = 4'd2,
        PH_UPLOW_AT  = 4'd3,
        PH_AT        = 4'd4,
        PH_AT_CLOSE  = 4'd5,
        PH_AT_SP     = 4'd6,
        PH_PENDING   = 4'd7,
        PH_ST_CLOSE  = 4'd8,
        PH_ST_SP     = 4'd9,
        PH_AFTER_CR  = 4'd10
    } t_phase;

    // Terminator kind of a finished sentence
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ATERM = 2'd1,
        KIND_STERM = 2'd2,
        KIND_PARA  = 2'd3
    } t_kind;

    // Capacity of the result bundle, an upper bound on the results one code point can cause
    localparam int unsigned MAX_RESULTS = 3;

    // Control part of the scan state
    typedef struct packed {
        t_phase phase;
        logic   absorb;
        logic   at_start;
    } t_scan_ctl;

    localparam t_scan_ctl SCAN_CTL_RESET = '{phase: PH_START, absorb: 1'b0, at_start: 1'b1};

    // Description of the results produced by one step
    typedef struct packed {
        logic [1:0] count;
        logic       text_end;
    } t_bundle_ctl;

endpackage

[src/sbs_step.sv]
// Combinational next-state and result logic of the sentence boundary scanner.
// Depends on sbs_pkg; instantiated by sentence_boundary_scanner.
module sbs_step
    import sbs_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                                  i_crlf_as_space,
    input  logic [3:0]                            i_char_class,
    input  logic [2:0]                            i_char_bytes,
    input  logic                                  i_text_end,
    input  t_scan_ctl                             i_ctl,
    input  logic [LENGTH_BITS-1:0]                i_sentence_bytes,
    input  logic [LENGTH_BITS-1:0]                i_pending_bytes,
    output t_scan_ctl                             o_ctl,
    output logic [LENGTH_BITS-1:0]                o_sentence_bytes,
    output logic [LENGTH_BITS-1:0]                o_pending_bytes,
    output logic [MAX_RESULTS-1:0][LENGTH_BITS-1:0] o_len,
    output t_kind [MAX_RESULTS-1:0]               o_kind,
    output t_bundle_ctl                           o_bundle
);

    localparam int unsigned L = LENGTH_BITS;

    typedef struct packed {
        t_phase                          phase;
        logic [L-1:0]                    sb;
        logic [L-1:0]                    pb;
        logic [1:0]                      cnt;
        logic [MAX_RESULTS-1:0][L-1:0]   len;
        t_kind [MAX_RESULTS-1:0]         kind;
    } t_work;

    function automatic logic [L-1:0] f_sat(logic [L-1:0] a, logic [L-1:0] b);
        logic [L:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[L] ? {L{1'b1}} : s[L-1:0];
    endfunction

    function automatic logic [L-1:0] f_ext(logic [2:0] b);
        return {{(L-3){1'b0}}, b};
    endfunction

    function automatic t_work f_emit(t_work w, logic [L-1:0] len, t_kind k);
        t_work r;
        r = w;
        if (r.cnt != 2'(MAX_RESULTS)) begin
            r.len[r.cnt]  = len;
            r.kind[r.cnt] = k;
            r.cnt         = r.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic t_work f_take(t_work w, logic [2:0] b);
        t_work r;
        r    = w;
        r.sb = f_sat(r.sb, f_ext(b));
        return r;
    endfunction

    function automatic t_work f_parasep(t_work w);
        t_work r;
        r       = f_emit(w, w.sb, KIND_PARA);
        r.sb    = '0;
        r.phase = PH_START;
        return r;
    endfunction

    // Code point already counted: pick the phase from the sentence-body rules
    function automatic t_work f_body(t_work w, t_char_class c, logic crlf);
        t_work r;
        r = w;
        unique case (c)
            CL_CR: begin
                r.phase = crlf ? PH_BODY : PH_AFTER_CR;
            end
            CL_LF: begin
                if (crlf) r.phase = PH_BODY;
                else      r = f_parasep(r);
            end
            CL_SEP: begin
                r = f_parasep(r);
            end
            CL_UPPER, CL_LOWER: begin
                r.phase = PH_UPLOW;
            end
            CL_ATERM: begin
                r.phase = PH_AT;
            end
            CL_STERM: begin
                r.phase = PH_ST_CLOSE;
            end
            default: begin
                r.phase = PH_BODY;
            end
        endcase
        return r;
    endfunction

    function automatic t_work f_restart(t_work w, t_kind k, t_char_class c, logic [2:0] b,
                                        logic crlf);
        t_work r;
        r    = f_emit(w, w.sb, k);
        r.sb = '0;
        r    = f_take(r, b);
        r    = f_body(r, c, crlf);
        return r;
    endfunction

    function automatic logic f_is_common(t_char_class c);
        return (c == CL_SP) || (c == CL_CR) || (c == CL_LF) || (c == CL_SEP) ||
               (c == CL_SCONT) || (c == CL_STERM) || (c == CL_ATERM);
    endfunction

    // Shared handling after a terminator, space phase given by the caller
    function automatic t_work f_common(t_work w, t_char_class c, logic [2:0] b,
                                       t_phase sp_phase, logic crlf);
        t_work r;
        r = f_take(w, b);
        unique case (c)
            CL_SP:    r.phase = sp_phase;
            CL_CR:    r.phase = crlf ? sp_phase : PH_AFTER_CR;
            CL_LF: begin
                if (crlf) r.phase = sp_phase;
                else      r = f_parasep(r);
            end
            CL_SEP:   r = f_parasep(r);
            CL_SCONT: r.phase = PH_BODY;
            CL_STERM: r.phase = PH_ST_CLOSE;
            CL_ATERM: r.phase = PH_AT;
            default:  r.phase = w.phase;
        endcase
        return r;
    endfunction

    function automatic t_work f_aterm_sp(t_work w, t_char_class c, logic [2:0] b, logic crlf);
        t_work r;
        r = w;
        priority if (f_is_common(c)) begin
            r = f_common(w, c, b, PH_AT_SP, crlf);
        end else if ((c == CL_OLETTER) || (c == CL_UPPER)) begin
            r = f_restart(w, KIND_ATERM, c, b, crlf);
        end else if (c == CL_LOWER) begin
            r       = f_take(w, b);
            r.phase = PH_UPLOW;
        end else begin
            // Hold the run until it is clear whether a lower-case letter follows
            r.pb    = f_ext(b);
            r.phase = PH_PENDING;
        end
        return r;
    endfunction

    function automatic t_work f_aterm_closers(t_work w, t_char_class c, logic [2:0] b,
                                              logic crlf);
        t_work r;
        if (c == CL_CLOSE) begin
            r       = f_take(w, b);
            r.phase = PH_AT_CLOSE;
        end else begin
            r = f_aterm_sp(w, c, b, crlf);
        end
        return r;
    endfunction

    function automatic t_work f_aterm_chain(t_work w, t_char_class c, logic [2:0] b, logic crlf);
        t_work r;
        if (c == CL_NUMERIC) begin
            r       = f_take(w, b);
            r.phase = PH_BODY;
        end else begin
            r = f_aterm_closers(w, c, b, crlf);
        end
        return r;
    endfunction

    function automatic t_work f_sterm_sp(t_work w, t_char_class c, logic [2:0] b, logic crlf);
        t_work r;
        if (f_is_common(c)) r = f_common(w, c, b, PH_ST_SP, crlf);
        else                r = f_restart(w, KIND_STERM, c, b, crlf);
        return r;
    endfunction

    function automatic t_work f_pending(t_work w, t_char_class c, logic [2:0] b, logic crlf);
        t_work r;
        logic  stop;
        stop = (c == CL_OLETTER) || (c == CL_UPPER) || (c == CL_SEP) ||
               (c == CL_STERM) || (c == CL_ATERM) ||
               (((c == CL_CR) || (c == CL_LF)) && !crlf);
        r = w;
        priority if (c == CL_LOWER) begin
            r.sb = f_sat(w.sb, w.pb);
            r.pb = '0;
            r    = f_take(r, b);
            r    = f_body(r, c, crlf);
        end else if (stop) begin
            r    = f_emit(w, w.sb, KIND_ATERM);
            r.sb = w.pb;
            r.pb = '0;
            r    = f_take(r, b);
            r    = f_body(r, c, crlf);
        end else begin
            r.pb = f_sat(w.pb, f_ext(b));
        end
        return r;
    endfunction

    function automatic t_work f_feed(t_work w, t_char_class c, logic [2:0] b, logic crlf);
        t_work r;
        r = w;
        unique case (w.phase)
            PH_UPLOW: begin
                r = f_take(w, b);
                if (c == CL_ATERM) r.phase = PH_UPLOW_AT;
                else               r = f_body(r, c, crlf);
            end
            PH_UPLOW_AT: begin
                if (c == CL_UPPER) begin
                    r       = f_take(w, b);
                    r.phase = PH_UPLOW;
                end else begin
                    r = f_aterm_chain(w, c, b, crlf);
                end
            end
            PH_AT:       r = f_aterm_chain(w, c, b, crlf);
            PH_AT_CLOSE: r = f_aterm_closers(w, c, b, crlf);
            PH_AT_SP:    r = f_aterm_sp(w, c, b, crlf);
            PH_PENDING:  r = f_pending(w, c, b, crlf);
            PH_ST_CLOSE: begin
                if (c == CL_CLOSE) r = f_take(w, b);
                else               r = f_sterm_sp(w, c, b, crlf);
            end
            PH_ST_SP:    r = f_sterm_sp(w, c, b, crlf);
            PH_AFTER_CR: begin
                if (c == CL_LF) begin
                    r = f_take(w, b);
                    r = f_parasep(r);
                end else begin
                    r = f_restart(w, KIND_PARA, c, b, crlf);
                end
            end
            default: begin
                r = f_take(w, b);
                r = f_body(r, c, crlf);
            end
        endcase
        return r;
    endfunction

    // Flush what is left at the end of a text
    function automatic t_work f_finish(t_work w);
        t_work r;
        r = w;
        unique case (w.phase)
            PH_START: ;
            PH_UPLOW_AT, PH_AT, PH_AT_CLOSE, PH_AT_SP:
                r = f_emit(r, w.sb, KIND_ATERM);
            PH_PENDING: begin
                r = f_emit(r, w.sb, KIND_ATERM);
                r = f_emit(r, w.pb, KIND_NONE);
            end
            PH_ST_CLOSE, PH_ST_SP:
                r = f_emit(r, w.sb, KIND_STERM);
            PH_AFTER_CR:
                r = f_emit(r, w.sb, KIND_PARA);
            default:
                r = f_emit(r, w.sb, KIND_NONE);
        endcase
        if (r.cnt == 2'd0) r = f_emit(r, '0, KIND_NONE);
        r.phase = PH_START;
        r.sb    = '0;
        r.pb    = '0;
        return r;
    endfunction

    t_char_class cls;
    logic        is_ext;
    logic        bare_end;
    t_work       w;
    t_scan_ctl   ctl;

    assign cls      = (i_char_class > CL_FORMAT) ? CL_OTHER : t_char_class'(i_char_class);
    assign is_ext   = (cls == CL_EXTEND) || (cls == CL_FORMAT);
    assign bare_end = i_text_end && (i_char_bytes == 3'd0);

    always_comb begin
        w       = '0;
        w.phase = i_ctl.phase;
        w.sb    = i_sentence_bytes;
        w.pb    = i_pending_bytes;
        ctl     = i_ctl;

        if (!bare_end) begin
            if (is_ext && i_ctl.absorb && !i_ctl.at_start) begin
                // Fold Extend/Format into the code point before it
                if (i_ctl.phase == PH_PENDING) w.pb = f_sat(w.pb, f_ext(i_char_bytes));
                else                           w = f_take(w, i_char_bytes);
            end else begin
                w          = f_feed(w, cls, i_char_bytes, i_crlf_as_space);
                ctl.absorb = !((cls == CL_SEP) ||
                               (((cls == CL_CR) || (cls == CL_LF)) && !i_crlf_as_space));
            end
            ctl.at_start = 1'b0;
        end

        if (i_text_end) begin
            w            = f_finish(w);
            ctl.absorb   = 1'b0;
            ctl.at_start = 1'b1;
        end
        ctl.phase = w.phase;
    end

    assign o_ctl             = ctl;
    assign o_sentence_bytes  = w.sb;
    assign o_pending_bytes   = w.pb;
    assign o_len             = w.len;
    assign o_kind            = w.kind;
    assign o_bundle.count    = w.cnt;
    assign o_bundle.text_end = i_text_end;

endmodule

[src/sentence_boundary_scanner.sv]
// Top level of the sentence boundary scanner: input register, scan state,
// result bundle and output serialiser. Depends on sbs_pkg and sbs_step.
//
// Feed one code point per transfer as its sentence-break class and UTF-8
// byte count, with tlast on the last code point of a text (a transfer with
// zero bytes and tlast ends a text without adding a code point; alone it
// gives one empty sentence). Each finished sentence leaves as one transfer
// carrying its saturating byte length, its terminator kind and a flag for
// the last result of the code point that caused it; tlast marks the final
// sentence of a text. Rate: one code point per cycle for code points that
// finish no sentence or one sentence, while the sentence stream is ready; a
// code point that finishes more sentences holds the input while the single
// output port drains the result bundle one sentence a cycle, while the
// receiver is ready. A code point passes the input register, then the scan
// step into the registered result bundle. The crlf_as_space register is
// written through the cfg channel, which is always ready; write it only
// while no text is in progress.
module sentence_boundary_scanner
    import sbs_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_data,       // crlf_as_space
    // Code point stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [3:0] char_class, [6:4] char_bytes
    input  logic                   i_s_axis_tlast,   // text_end
    // Sentence stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [((LENGTH_BITS+7)/8)*8-1:0] o_m_axis_tdata,  // sentence_length
    output logic [2:0]             o_m_axis_tuser,   // [1:0] sentence_kind, [2] run_last
    output logic                   o_m_axis_tlast    // text_done
);

    localparam int unsigned TDATA_W = ((LENGTH_BITS + 7) / 8) * 8;

    // Configuration
    logic r_crlf;

    // Input register
    logic       r_in_vld;
    logic [3:0] r_in_class;
    logic [2:0] r_in_bytes;
    logic       r_in_end;

    // Scan state
    t_scan_ctl              r_ctl;
    logic [LENGTH_BITS-1:0] r_sb;
    logic [LENGTH_BITS-1:0] r_pb;
    t_scan_ctl              n_ctl;
    logic [LENGTH_BITS-1:0] n_sb;
    logic [LENGTH_BITS-1:0] n_pb;

    // Result bundle
    logic                                     r_bun_busy;
    logic [1:0]                               r_bun_idx;
    logic [1:0]                               r_bun_cnt;
    logic                                     r_bun_end;
    logic [MAX_RESULTS-1:0][LENGTH_BITS-1:0]  r_bun_len;
    t_kind [MAX_RESULTS-1:0]                  r_bun_kind;
    logic [MAX_RESULTS-1:0][LENGTH_BITS-1:0]  n_len;
    t_kind [MAX_RESULTS-1:0]                  n_kind;
    t_bundle_ctl                              n_bundle;

    logic s_fire;
    logic m_fire;
    logic run_last;
    logic bun_free;
    logic step_fire;

    assign o_cfg_ready = 1'b1;

    assign run_last  = (r_bun_idx == (r_bun_cnt - 2'd1));
    assign m_fire    = o_m_axis_tvalid && i_m_axis_tready;
    // Bundle can take the next step when empty or on its final transfer
    assign bun_free  = !r_bun_busy || (m_fire && run_last);
    assign step_fire = r_in_vld && bun_free;
    assign o_s_axis_tready = !r_in_vld || step_fire;
    assign s_fire    = i_s_axis_tvalid && o_s_axis_tready;

    sbs_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .i_crlf_as_space  (r_crlf),
        .i_char_class     (r_in_class),
        .i_char_bytes     (r_in_bytes),
        .i_text_end       (r_in_end),
        .i_ctl            (r_ctl),
        .i_sentence_bytes (r_sb),
        .i_pending_bytes  (r_pb),
        .o_ctl            (n_ctl),
        .o_sentence_bytes (n_sb),
        .o_pending_bytes  (n_pb),
        .o_len            (n_len),
        .o_kind           (n_kind),
        .o_bundle         (n_bundle)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crlf     <= 1'b0;
            r_in_vld   <= 1'b0;
            r_ctl      <= SCAN_CTL_RESET;
            r_sb       <= '0;
            r_pb       <= '0;
            r_bun_busy <= 1'b0;
            r_bun_idx  <= 2'd0;
            r_bun_cnt  <= 2'd0;
            r_bun_end  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_crlf <= i_cfg_data;
            end
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (step_fire) begin
                // Advance the scan state and load this code point's results
                r_ctl      <= n_ctl;
                r_sb       <= n_sb;
                r_pb       <= n_pb;
                r_bun_busy <= (n_bundle.count != 2'd0);
                r_bun_idx  <= 2'd0;
                r_bun_cnt  <= n_bundle.count;
                r_bun_end  <= n_bundle.text_end;
            end else if (m_fire) begin
                if (run_last) r_bun_busy <= 1'b0;
                else          r_bun_idx  <= r_bun_idx + 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_class <= i_s_axis_tdata[3:0];
            r_in_bytes <= i_s_axis_tdata[6:4];
            r_in_end   <= i_s_axis_tlast;
        end
        if (step_fire) begin
            r_bun_len  <= n_len;
            r_bun_kind <= n_kind;
        end
    end

    assign o_m_axis_tvalid = r_bun_busy;
    assign o_m_axis_tdata  = TDATA_W'(r_bun_len[r_bun_idx]);
    assign o_m_axis_tuser  = {run_last, r_bun_kind[r_bun_idx]};
    assign o_m_axis_tlast  = run_last && r_bun_end;

    // A busy bundle never points past its last result
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bun_busy |-> (r_bun_idx < r_bun_cnt))
        else $error("result index beyond bundle count");

    // End of text always yields at least one sentence
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && r_in_end) |=> r_bun_busy)
        else $error("text end produced no result");

    // End of text returns the scan to the start of a fresh text
    a_end_resets_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && r_in_end) |=> ((r_ctl.phase == PH_START) && r_ctl.at_start &&
                                     (r_sb == '0)))
        else $error("scan state not cleared after text end");

    // Held bytes exist only while a look-ahead is pending
    a_pending_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.phase != PH_PENDING) |-> (r_pb == '0))
        else $error("pending bytes outside pending phase");

    // Text done only on the last result of a code point
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser[2])
        else $error("text done before last result");

endmodule

[verif/tb.sv]
// Self-checking bench for sentence_boundary_scanner: drives code points and checks every
// sentence transfer against a cycle-free scan model kept here.
// Depends on sbs_pkg and the scanner RTL only.
`timescale 1ns / 100ps

module tb;
    import sbs_pkg::*;

    localparam int LEN_BITS             = 16;
    localparam logic [3:0] CLASS_SPARE  = 4'd15;    // outside the class table, scans as Other
    localparam int HOLD_CYCLES          = 64;
    localparam int SETTLE_CYCLES        = 4;
    localparam int WATCHDOG_LIMIT       = 2000;

    typedef struct packed {
        logic [3:0] cls;
        logic [2:0] nbytes;
        logic       text_end;
    } t_code_point;

    typedef struct packed {
        logic [LEN_BITS-1:0] len;
        t_kind               kind;
        logic                done;
        logic                last;
    } t_sentence;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;    // [3:0] char_class, [6:4] char_bytes
    logic                s_tlast   = 1'b0;  // text_end
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [LEN_BITS-1:0] m_tdata;           // sentence_length
    logic [2:0]          m_tuser;           // [1:0] sentence_kind, [2] run_last
    logic                m_tlast;           // text_done

    sentence_boundary_scanner #(.LENGTH_BITS(LEN_BITS)) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Stimulus and expectation stores
    t_code_point code_point_q[$];
    t_code_point text_buf[$];
    t_sentence   sentence_q[$];

    int cp_taken       = 0;
    int sentences_seen = 0;
    int texts_ended    = 0;
    int cfg_writes     = 0;
    int fail_count     = 0;
    int idle_cycles    = 0;
    int hold_req       = 0;

    // ------------------------------------------------------------------
    // Scan model: state and configuration as the block holds them
    // ------------------------------------------------------------------
    logic                crlf_mode = 1'b0;
    t_phase              scan_ph   = PH_START;
    logic                absorb    = 1'b0;
    logic                at_start  = 1'b1;
    logic [LEN_BITS-1:0] sent_len  = '0;
    logic [LEN_BITS-1:0] pend_len  = '0;
    int                  step_n;

    function automatic logic [LEN_BITS-1:0] sat_sum(logic [LEN_BITS-1:0] a,
                                                     logic [LEN_BITS-1:0] b);
        logic [LEN_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[LEN_BITS])
            return '1;
        return s[LEN_BITS-1:0];
    endfunction

    function automatic void grow(logic [2:0] b);
        sent_len = sat_sum(sent_len, LEN_BITS'(b));
    endfunction

    function automatic void close_sentence(logic [LEN_BITS-1:0] len, t_kind kind);
        t_sentence s;
        s.len  = len;
        s.kind = kind;
        s.done = 1'b0;
        s.last = 1'b0;
        sentence_q.push_back(s);
        step_n++;
    endfunction

    // Set text_done or run_last on the newest expectation
    function automatic void flag_tail(bit done_flag);
        t_sentence s;
        s = sentence_q.pop_back();
        if (done_flag) begin
            s.done = 1'b1;
        end else begin
            s.last = 1'b1;
        end
        sentence_q.push_back(s);
    endfunction

    function automatic void para_break();
        close_sentence(sent_len, KIND_PARA);
        sent_len = '0;
        scan_ph  = PH_START;
    endfunction

    // Code point already counted: pick the next phase from the body rules
    function automatic void body_phase(t_char_class c);
        case (c)
            CL_CR: begin
                if (crlf_mode) scan_ph = PH_BODY; else scan_ph = PH_AFTER_CR;
            end
            CL_LF: begin
                if (crlf_mode) scan_ph = PH_BODY; else para_break();
            end
            CL_SEP:             para_break();
            CL_UPPER, CL_LOWER: scan_ph = PH_UPLOW;
            CL_ATERM:           scan_ph = PH_AT;
            CL_STERM:           scan_ph = PH_ST_CLOSE;
            default:            scan_ph = PH_BODY;
        endcase
    endfunction

    function automatic void restart(t_kind kind, t_char_class c, logic [2:0] b);
        close_sentence(sent_len, kind);
        sent_len = '0;
        grow(b);
        body_phase(c);
    endfunction

    // Classes treated alike after either terminator; returns 0 if none matched
    function automatic bit after_term(t_char_class c, logic [2:0] b, t_phase sp_ph);
        bit hit;
        hit = 1'b1;
        case (c)
            CL_SP: begin
                grow(b);
                scan_ph = sp_ph;
            end
            CL_CR: begin
                grow(b);
                if (crlf_mode) scan_ph = sp_ph; else scan_ph = PH_AFTER_CR;
            end
            CL_LF: begin
                grow(b);
                if (crlf_mode) scan_ph = sp_ph; else para_break();
            end
            CL_SEP: begin
                grow(b);
                para_break();
            end
            CL_SCONT: begin
                grow(b);
                scan_ph = PH_BODY;
            end
            CL_STERM: begin
                grow(b);
                scan_ph = PH_ST_CLOSE;
            end
            CL_ATERM: begin
                grow(b);
                scan_ph = PH_AT;
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic void aterm_space(t_char_class c, logic [2:0] b);
        if (!after_term(c, b, PH_AT_SP)) begin
            if (c == CL_OLETTER || c == CL_UPPER) begin
                restart(KIND_ATERM, c, b);
            end else if (c == CL_LOWER) begin
                grow(b);
                scan_ph = PH_UPLOW;
            end else begin
                // the break is undecided until a lower-case letter or a stopper shows up
                pend_len = sat_sum('0, LEN_BITS'(b));
                scan_ph  = PH_PENDING;
            end
        end
    endfunction

    function automatic void aterm_closers(t_char_class c, logic [2:0] b);
        if (c == CL_CLOSE) begin
            grow(b);
            scan_ph = PH_AT_CLOSE;
        end else begin
            aterm_space(c, b);
        end
    endfunction

    function automatic void aterm_chain(t_char_class c, logic [2:0] b);
        if (c == CL_NUMERIC) begin
            grow(b);
            scan_ph = PH_BODY;
        end else begin
            aterm_closers(c, b);
        end
    endfunction

    function automatic void sterm_space(t_char_class c, logic [2:0] b);
        if (!after_term(c, b, PH_ST_SP))
            restart(KIND_STERM, c, b);
    endfunction

    function automatic void settle_pending(t_char_class c, logic [2:0] b);
        bit stop;
        stop = c == CL_OLETTER || c == CL_UPPER || c == CL_SEP || c == CL_STERM ||
               c == CL_ATERM || ((c == CL_CR || c == CL_LF) && !crlf_mode);
        if (c == CL_LOWER) begin
            sent_len = sat_sum(sent_len, pend_len);
            pend_len = '0;
            grow(b);
            body_phase(c);
        end else if (stop) begin
            // break goes before the collected run, which opens the next sentence
            close_sentence(sent_len, KIND_ATERM);
            sent_len = pend_len;
            pend_len = '0;
            grow(b);
            body_phase(c);
        end else begin
            pend_len = sat_sum(pend_len, LEN_BITS'(b));
        end
    endfunction

    function automatic void feed(t_char_class c, logic [2:0] b);
        case (scan_ph)
            PH_UPLOW: begin
                grow(b);
                if (c == CL_ATERM) scan_ph = PH_UPLOW_AT; else body_phase(c);
            end
            PH_UPLOW_AT: begin
                if (c == CL_UPPER) begin
                    grow(b);
                    scan_ph = PH_UPLOW;
                end else begin
                    aterm_chain(c, b);
                end
            end
            PH_AT:       aterm_chain(c, b);
            PH_AT_CLOSE: aterm_closers(c, b);
            PH_AT_SP:    aterm_space(c, b);
            PH_PENDING:  settle_pending(c, b);
            PH_ST_CLOSE: begin
                if (c == CL_CLOSE) grow(b); else sterm_space(c, b);
            end
            PH_ST_SP:    sterm_space(c, b);
            PH_AFTER_CR: begin
                if (c == CL_LF) begin
                    grow(b);
                    para_break();
                end else begin
                    restart(KIND_PARA, c, b);
                end
            end
            default: begin
                grow(b);
                body_phase(c);
            end
        endcase
    endfunction

    function automatic void finish_text();
        case (scan_ph)
            PH_START: ;
            PH_UPLOW_AT, PH_AT, PH_AT_CLOSE, PH_AT_SP:
                close_sentence(sent_len, KIND_ATERM);
            PH_PENDING: begin
                close_sentence(sent_len, KIND_ATERM);
                close_sentence(pend_len, KIND_NONE);
            end
            PH_ST_CLOSE, PH_ST_SP: close_sentence(sent_len, KIND_STERM);
            PH_AFTER_CR:           close_sentence(sent_len, KIND_PARA);
            default:               close_sentence(sent_len, KIND_NONE);
        endcase
        if (step_n == 0)
            close_sentence('0, KIND_NONE);
        flag_tail(1'b1);
        scan_ph  = PH_START;
        absorb   = 1'b0;
        at_start = 1'b1;
        sent_len = '0;
        pend_len = '0;
        texts_ended++;
    endfunction

    // Work out the sentences one accepted code point finishes
    function automatic void scan_code_point(logic [3:0] raw, logic [2:0] nbytes,
                                            logic end_mark);
        t_char_class c;
        step_n = 0;
        if (raw == CLASS_SPARE) c = CL_OTHER; else c = t_char_class'(raw);
        // a zero-byte item with the end mark only closes the text
        if (!(end_mark && nbytes == 3'd0)) begin
            if ((c == CL_EXTEND || c == CL_FORMAT) && absorb && !at_start) begin
                if (scan_ph == PH_PENDING)
                    pend_len = sat_sum(pend_len, LEN_BITS'(nbytes));
                else
                    grow(nbytes);
            end else begin
                feed(c, nbytes);
                absorb = !(c == CL_SEP || ((c == CL_CR || c == CL_LF) && !crlf_mode));
            end
            at_start = 1'b0;
        end
        if (end_mark)
            finish_text();
        if (step_n > 0)
            flag_tail(1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check sentence transfers, predict on code point transfers
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_sentence exp_s;
        bit        moved;
        moved = 1'b0;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                sentences_seen++;
                if (sentence_q.size() == 0) begin
                    $error("sentence transfer with nothing expected: length %0d", m_tdata);
                    fail_count++;
                end else begin
                    exp_s = sentence_q.pop_front();
                    if (m_tdata !== exp_s.len) begin
                        $error("sentence_length: expected %0d, got %0d", exp_s.len, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[1:0] !== exp_s.kind) begin
                        $error("sentence_kind: expected %0d, got %0d", exp_s.kind,
                               m_tuser[1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_s.done) begin
                        $error("text_done: expected %0d, got %0d", exp_s.done, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[2] !== exp_s.last) begin
                        $error("run_last: expected %0d, got %0d", exp_s.last, m_tuser[2]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                cp_taken++;
                scan_code_point(s_tdata[3:0], s_tdata[6:4], s_tlast);
            end
            if (cfg_valid && cfg_ready)
                moved = 1'b1;
        end
        if (moved) idle_cycles = 0; else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer queued code points, random gaps with gap-free stretches
    // ------------------------------------------------------------------
    int          drv_seen = 0;
    int          drv_gap  = 0;
    int          drv_run  = 0;
    logic        drv_offer;
    t_code_point drv_cp;

    always @(negedge clk) begin
        if (rst_n) begin
            drv_offer = s_tvalid;
            if (drv_offer && cp_taken != drv_seen) begin
                drv_seen  = cp_taken;
                drv_offer = 1'b0;
                if (drv_run > 0) begin
                    drv_run--;
                    drv_gap = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    drv_run = $urandom_range(8, 30);
                    drv_gap = 0;
                end else begin
                    drv_gap = $urandom_range(0, 5);
                end
            end
            if (!drv_offer) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (code_point_q.size() != 0) begin
                    drv_cp = code_point_q.pop_front();
                    s_tdata   <= {1'b0, drv_cp.nbytes, drv_cp.cls};
                    s_tlast   <= drv_cp.text_end;
                    drv_offer = 1'b1;
                end
            end
            s_tvalid <= drv_offer;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls after sentences with stall-free stretches, plus long hold-offs on request
    // ------------------------------------------------------------------
    int   rx_seen      = 0;
    int   rx_wait      = 0;
    int   rx_run       = 0;
    int   rx_hold_seen = 0;
    int   rx_hold_left = 0;
    logic rx_ready;

    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_req != rx_hold_seen) begin
                rx_hold_seen = hold_req;
                rx_hold_left = HOLD_CYCLES;
            end
            if (sentences_seen != rx_seen) begin
                rx_seen = sentences_seen;
                if (rx_run > 0) begin
                    rx_run--;
                    rx_wait = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_run  = $urandom_range(8, 30);
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, 5);
                end
            end
            rx_ready = 1'b1;
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                rx_ready = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rx_ready = 1'b0;
            end
            m_tready <= rx_ready;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic t_code_point make_cp(logic [3:0] cls, logic [2:0] nb, logic e);
        t_code_point cp;
        cp.cls      = cls;
        cp.nbytes   = nb;
        cp.text_end = e;
        return cp;
    endfunction

    function automatic void push_cp(logic [3:0] cls, logic [2:0] nb, logic e);
        code_point_q.push_back(make_cp(cls, nb, e));
    endfunction

    // Mostly ordinary widths; now and then zero or oversized counts
    function automatic logic [2:0] random_bytes();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 3'd0;
        if (r == 1) return 3'($urandom_range(5, 7));
        return 3'($urandom_range(1, 4));
    endfunction

    function automatic logic [3:0] random_class();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            15:      return CL_ATERM;
            16:      return CL_SP;
            17:      return CL_CLOSE;
            18:      return CL_LOWER;
            19:      return CLASS_SPARE;
            default: return 4'(r);
        endcase
    endfunction

    function automatic void add_cp(logic [3:0] cls);
        text_buf.push_back(make_cp(cls, random_bytes(), 1'b0));
    endfunction

    // Sentence-shaped text: letters, terminator, closers, spaces, follow-up
    function automatic void build_shaped_text();
        int n_sent;
        n_sent = $urandom_range(1, 3);
        for (int k = 0; k < n_sent; k++) begin
            case ($urandom_range(0, 2))
                0:       add_cp(CL_UPPER);
                1:       add_cp(CL_LOWER);
                default: add_cp(CL_OLETTER);
            endcase
            repeat ($urandom_range(0, 3)) add_cp(random_class());
            if ($urandom_range(0, 1) == 0) add_cp(CL_ATERM); else add_cp(CL_STERM);
            repeat ($urandom_range(0, 2)) add_cp(CL_CLOSE);
            repeat ($urandom_range(0, 2)) begin
                case ($urandom_range(0, 5))
                    0:       add_cp(CL_CR);
                    1:       add_cp(CL_LF);
                    2:       add_cp(CL_EXTEND);
                    default: add_cp(CL_SP);
                endcase
            end
            if ($urandom_range(0, 2) == 0)
                add_cp(random_class());
        end
    endfunction

    // Close the text in the buffer, either on its last code point or with a bare end
    function automatic int send_text();
        t_code_point cp;
        if (text_buf.size() == 0 || $urandom_range(0, 4) == 0) begin
            text_buf.push_back(make_cp(random_class(), 3'd0, 1'b1));
        end else begin
            cp = text_buf.pop_back();
            cp.text_end = 1'b1;
            text_buf.push_back(cp);
        end
        foreach (text_buf[k])
            code_point_q.push_back(text_buf[k]);
        return text_buf.size();
    endfunction

    task automatic queue_random_texts(int n_items);
        int n_queued;
        n_queued = 0;
        while (n_queued < n_items) begin
            text_buf.delete();
            if ($urandom_range(0, 9) < 7) begin
                build_shaped_text();
            end else begin
                repeat ($urandom_range(0, 8)) add_cp(random_class());
            end
            n_queued += send_text();
        end
    endtask

    // Wait for the input queue and every expected sentence to drain
    task automatic drain();
        while (code_point_q.size() != 0 || s_tvalid || sentence_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_crlf(logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        crlf_mode = val;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Half a phase under a long receiver hold-off, a drain, then the other half and a full pause
    task automatic random_phase(int n_items);
        queue_random_texts(n_items / 2);
        hold_req++;
        drain();
        queue_random_texts(n_items - n_items / 2);
        drain();
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        write_crlf(1'b0);
        // empty text, then Extend leading a text
        push_cp(CL_OTHER,    3'd0, 1'b1);
        push_cp(CL_EXTEND,   3'd2, 1'b0);
        // Upper ATerm Upper stays one sentence
        push_cp(CL_UPPER,    3'd1, 1'b0);
        push_cp(CL_ATERM,    3'd1, 1'b0);
        push_cp(CL_UPPER,    3'd1, 1'b0);
        // ATerm Close Sp, undecided run with a Format inside, settled by Lower
        push_cp(CL_ATERM,    3'd1, 1'b0);
        push_cp(CL_CLOSE,    3'd3, 1'b0);
        push_cp(CL_SP,       3'd1, 1'b0);
        push_cp(CL_NUMERIC,  3'd1, 1'b0);
        push_cp(CL_FORMAT,   3'd2, 1'b0);
        push_cp(CL_LOWER,    3'd1, 1'b0);
        // STerm Close Sp (oversized count) then a break before OLetter
        push_cp(CL_STERM,    3'd4, 1'b0);
        push_cp(CL_CLOSE,    3'd1, 1'b0);
        push_cp(CL_SP,       3'd7, 1'b0);
        push_cp(CL_OLETTER,  3'd5, 1'b0);
        // CR LF together, Extend after the paragraph break stands alone
        push_cp(CL_CR,       3'd1, 1'b0);
        push_cp(CL_LF,       3'd6, 1'b0);
        push_cp(CL_EXTEND,   3'd1, 1'b0);
        // ATerm Numeric (zero-byte), SContinue, lone CR before the spare class
        push_cp(CL_ATERM,    3'd1, 1'b0);
        push_cp(CL_NUMERIC,  3'd0, 1'b0);
        push_cp(CL_SCONT,    3'd1, 1'b0);
        push_cp(CL_CR,       3'd1, 1'b0);
        push_cp(CLASS_SPARE, 3'd3, 1'b0);
        push_cp(CL_SEP,      3'd2, 1'b0);
        // text ends while the break is still undecided
        push_cp(CL_ATERM,    3'd1, 1'b0);
        push_cp(CL_SP,       3'd1, 1'b0);
        push_cp(CL_OTHER,    3'd1, 1'b1);
        drain();
        random_phase(80);

        write_crlf(1'b1);
        // CR and LF act as spaces; Extend after LF is absorbed
        push_cp(CL_ATERM,    3'd1, 1'b0);
        push_cp(CL_LF,       3'd1, 1'b0);
        push_cp(CL_EXTEND,   3'd2, 1'b0);
        push_cp(CL_OTHER,    3'd1, 1'b0);
        push_cp(CL_CR,       3'd1, 1'b0);
        push_cp(CL_SP,       3'd1, 1'b1);
        random_phase(80);

        // paragraph breaks on CR and LF again
        write_crlf(1'b0);
        random_phase(80);
        repeat (8) @(posedge clk);

        $display("Covered %0d code points in %0d texts, %0d sentences checked,", cp_taken,
                 texts_ended, sentences_seen);
        $display("%0d writes of crlf_as_space over both settings, with stalls and hold-offs",
                 cfg_writes);
        if (fail_count == 0 && sentence_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d sentences still expected", fail_count,
                     sentence_q.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
src/sbs_pkg.sv
src/sbs_step.sv
src/sentence_boundary_scanner.sv
verif/tb.sv
